// ----- sv/jfs_pkg.sv -----
package jfs_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int SAMPLE_W   = 32;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 12;
  localparam int CFG_ROWS_W = 11;
  localparam int CFG_COLS_W = 12;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(1024);
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(1024);

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;
    logic             produce;
  } pos_t;

endpackage

// ----- sv/jacobi_five_point_stencil_top.sv -----
// a result passes stage 1 and then the output register after the transfer of the sample
// that completes its right neighbor; ghost column zero gives no results
// throughput: one sample per cycle unless output stalls; one write, one read per ram port
// reset: counters and pipeline valids cleared, rows_in_use and cols_in_use set to 1024;
// line store contents are undefined until written and get no clearing pass
module jacobi_five_point_stencil_top #(
  parameter int MAX_COLS = 4094
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [jfs_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [jfs_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] value, [41:32] row,
                                                          // [53:42] column, [55:54] zero
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [jfs_pkg::APB_AW-1:0]          cfg_paddr,
  input  logic [jfs_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [jfs_pkg::APB_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  import jfs_pkg::*;

  localparam int NRW = $clog2(MAX_ROWS + 1);
  localparam int NCW = $clog2(MAX_COLS + 3);
  localparam int AW  = $clog2(2 * MAX_ROWS);

  logic [CFG_ROWS_W-1:0] rows_in_use_r, rows_in_use_nxt;
  logic [CFG_COLS_W-1:0] cols_in_use_r, cols_in_use_nxt;
  logic                  cfg_wr;
  reg_sel_t              cfg_sel;
  logic [NRW-1:0]        nrows;
  logic [NCW-1:0]        ncols;
  logic                  in_acc;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         up_addr;
  logic [AW-1:0]         dn_addr;
  pos_t                  pos;
  logic [1:0][SAMPLE_W-1:0] nb_data;
  logic [0:0][SAMPLE_W-1:0] lf_data;
  logic signed [SAMPLE_W-1:0] value;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      column;

  function automatic logic [NRW-1:0] sat_rows(input logic [CFG_ROWS_W-1:0] v);
    if (int'(v) < 2) begin
      sat_rows = NRW'(2);
    end else if (int'(v) > MAX_ROWS) begin
      sat_rows = NRW'(MAX_ROWS);
    end else begin
      sat_rows = NRW'(v);
    end
  endfunction

  function automatic logic [NCW-1:0] sat_cols(input logic [CFG_COLS_W-1:0] v);
    if (int'(v) < 2) begin
      sat_cols = NCW'(2 + 2);
    end else if (int'(v) > MAX_COLS) begin
      sat_cols = NCW'(MAX_COLS + 2);
    end else begin
      sat_cols = NCW'(int'(v) + 2);
    end
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_comb begin
    rows_in_use_nxt = rows_in_use_r;
    cols_in_use_nxt = cols_in_use_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_ROWS: rows_in_use_nxt = cfg_pwdata[CFG_ROWS_W-1:0];
        REG_COLS: cols_in_use_nxt = cfg_pwdata[CFG_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROWS: cfg_prdata = APB_DW'(rows_in_use_r);
      REG_COLS: cfg_prdata = APB_DW'(cols_in_use_r);
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      cols_in_use_r <= COLS_RESET;
    end else begin
      rows_in_use_r <= rows_in_use_nxt;
      cols_in_use_r <= cols_in_use_nxt;
    end
  end

  assign nrows  = sat_rows(rows_in_use_r);
  assign ncols  = sat_cols(cols_in_use_r);
  assign in_acc = in_tvalid & in_tready;

  jfs_seq #(
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_wr),
    .adv     (in_acc),
    .nrows   (nrows),
    .ncols   (ncols),
    .wr_addr (wr_addr),
    .up_addr (up_addr),
    .dn_addr (dn_addr),
    .pos     (pos)
  );

  // neighbor column copy: up and down reads
  jfs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 * MAX_ROWS),
    .NRD   (2)
  ) u_ram_nb (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wr_addr),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .re    (in_acc),
    .raddr ({dn_addr, up_addr}),
    .rdata (nb_data)
  );

  // second copy: left neighbor sits where the new sample is written
  jfs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 * MAX_ROWS),
    .NRD   (1)
  ) u_ram_lf (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wr_addr),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .re    (in_acc),
    .raddr (wr_addr),
    .rdata (lf_data)
  );

  jfs_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .pos_i     (pos),
    .sample_i  (in_tdata[SAMPLE_W-1:0]),
    .up_i      (nb_data[0]),
    .dn_i      (nb_data[1]),
    .lf_i      (lf_data[0]),
    .take      (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .value     (value),
    .row       (row),
    .column    (column),
    .last      (out_tlast)
  );

  assign out_tdata = {2'b00, column, row, value};

endmodule

// ----- sv/jfs_ram.sv -----
module jfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int NRD   = 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [NRD-1:0][AW-1:0]     raddr,
  output logic [NRD-1:0][WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0]          mem_r [DEPTH];
  logic [NRD-1:0][WIDTH-1:0] rdata_r;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      for (int i = 0; i < NRD; i++) begin
        rdata_r[i] <= mem_r[raddr[i]];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/jfs_seq.sv -----
module jfs_seq #(
  parameter int MAX_COLS = 4094,
  localparam int RW  = $clog2(jfs_pkg::MAX_ROWS),
  localparam int NRW = $clog2(jfs_pkg::MAX_ROWS + 1),
  localparam int CW  = $clog2(MAX_COLS + 2),
  localparam int NCW = $clog2(MAX_COLS + 3),
  localparam int AW  = $clog2(2 * jfs_pkg::MAX_ROWS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               adv,
  input  logic [NRW-1:0]     nrows,
  input  logic [NCW-1:0]     ncols,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      up_addr,
  output logic [AW-1:0]      dn_addr,
  output jfs_pkg::pos_t      pos
);

  import jfs_pkg::*;

  logic [RW-1:0]  r_r, r_nxt;
  logic [CW-1:0]  c_r, c_nxt;
  logic [NRW-1:0] r_inc;
  logic [NCW-1:0] c_inc;
  logic           r_last;
  logic           c_last;
  logic [RW-1:0]  up_row;
  logic [RW-1:0]  dn_row;

  function automatic logic [AW-1:0] slot_addr(input logic par, input logic [RW-1:0] row);
    slot_addr = par ? (AW'(MAX_ROWS) + AW'(row)) : AW'(row);
  endfunction

  assign r_inc  = NRW'(r_r) + NRW'(1);
  assign c_inc  = NCW'(c_r) + NCW'(1);
  assign r_last = (r_inc == nrows);
  assign c_last = (c_inc == ncols);

  // periodic wrap over rows
  assign up_row = (r_r == '0) ? RW'(nrows - NRW'(1)) : r_r - RW'(1);
  assign dn_row = r_last ? '0 : r_r + RW'(1);

  assign wr_addr = slot_addr(c_r[0], r_r);
  assign up_addr = slot_addr(~c_r[0], up_row);
  assign dn_addr = slot_addr(~c_r[0], dn_row);

  assign pos.row     = ROW_W'(r_r);
  assign pos.column  = COL_W'(c_r - CW'(1));
  assign pos.last    = r_last & c_last;
  assign pos.produce = (c_r >= CW'(2));

  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    if (clr) begin
      r_nxt = '0;
      c_nxt = '0;
    end else if (adv) begin
      if (r_last) begin
        r_nxt = '0;
        c_nxt = c_last ? '0 : c_r + CW'(1);
      end else begin
        r_nxt = r_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      c_r <= '0;
    end else begin
      r_r <= r_nxt;
      c_r <= c_nxt;
    end
  end

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    NRW'(r_r) < nrows) else $error("row counter out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    NCW'(c_r) < ncols) else $error("column counter out of range");

  a_last_produces: assert property (@(posedge clk) disable iff (!rst_n)
    pos.last |-> pos.produce) else $error("frame end on a ghost column");

endmodule

// ----- sv/jfs_update.sv -----
module jfs_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  jfs_pkg::pos_t                     pos_i,
  input  logic signed [jfs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [jfs_pkg::SAMPLE_W-1:0] up_i,
  input  logic signed [jfs_pkg::SAMPLE_W-1:0] dn_i,
  input  logic signed [jfs_pkg::SAMPLE_W-1:0] lf_i,
  output logic                              take,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [jfs_pkg::SAMPLE_W-1:0] value,
  output logic [jfs_pkg::ROW_W-1:0]         row,
  output logic [jfs_pkg::COL_W-1:0]         column,
  output logic                              last
);

  import jfs_pkg::*;

  logic                       s1_v_r, s1_v_nxt;
  pos_t                       s1_pos_r;
  logic signed [SAMPLE_W-1:0] s1_smp_r;
  logic                       s1_go;
  logic                       out_v_r, out_v_nxt;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [SAMPLE_W-1:0] value_r;
  logic [ROW_W-1:0]           row_r;
  logic [COL_W-1:0]           column_r;
  logic                       last_r;

  // ram words line up with stage 1 since the read is enabled by the transfer
  assign sum = (SAMPLE_W+2)'(up_i) + (SAMPLE_W+2)'(dn_i)
             + (SAMPLE_W+2)'(lf_i) + (SAMPLE_W+2)'(s1_smp_r);

  assign s1_go = s1_v_r & (~s1_pos_r.produce | ~out_v_r | out_ready);
  assign take  = ~s1_v_r | s1_go;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && s1_pos_r.produce) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pos_r <= pos_i;
      s1_smp_r <= sample_i;
    end
    if (s1_go && s1_pos_r.produce) begin
      value_r  <= sum[SAMPLE_W+1:2];
      row_r    <= s1_pos_r.row;
      column_r <= s1_pos_r.column;
      last_r   <= s1_pos_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign value     = value_r;
  assign row       = row_r;
  assign column    = column_r;
  assign last      = last_r;

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_v_r && s1_pos_r.produce))
    else $error("result without a producing stage 1 item");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> take) else $error("stage 1 overwritten");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_smp_r)))
    else $error("stalled stage 1 item lost");

endmodule

// ----- dv/jacobi_five_point_stencil_top_tb.sv -----
`timescale 1ns / 100ps
module jacobi_five_point_stencil_top_tb;
  import jfs_pkg::*;

  localparam int MAX_COLS    = 4094;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 4;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic                last;
  } stencil_point_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [APB_AW-1:0]      cfg_paddr;
  logic [APB_DW-1:0]      cfg_pwdata;
  logic [APB_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // grid model
  logic signed [SAMPLE_W-1:0] line_store [2*MAX_ROWS];
  int unsigned                next_row;
  int unsigned                next_col;
  logic [CFG_ROWS_W-1:0]      rows_reg;
  logic [CFG_COLS_W-1:0]      cols_reg;
  stencil_point_t             pending_points[$];
  stencil_point_t             expected_point;

  int unsigned errors;
  int unsigned cycles;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  jacobi_five_point_stencil_top #(
    .MAX_COLS(MAX_COLS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  function automatic int unsigned rows_used();
    if (rows_reg < 2) return 2;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned cols_used();
    if (cols_reg < 2) return 2;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned frame_length();
    return rows_used() * (cols_used() + 2);
  endfunction

  function automatic int unsigned slot(int unsigned col, int unsigned row);
    return (col % 2) * MAX_ROWS + row;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR %s", msg);
  endtask

  // update the grid model with one accepted sample
  task automatic predict_point(input logic [SAMPLE_W-1:0] sample);
    int unsigned    nrows;
    int unsigned    ncols;
    int unsigned    r;
    int unsigned    c;
    int unsigned    up;
    int unsigned    dn;
    longint         sum;
    stencil_point_t p;
    nrows = rows_used();
    ncols = cols_used() + 2;
    r = next_row;
    c = next_col;
    if (r >= nrows) r = 0;
    if (c >= ncols) c = 0;
    if (c >= 2) begin
      up = (r == 0) ? nrows - 1 : r - 1;
      dn = (r + 1 >= nrows) ? 0 : r + 1;
      sum = longint'(line_store[slot(c - 1, up)]) + longint'(line_store[slot(c - 1, dn)])
          + longint'(line_store[slot(c - 2, r)]) + longint'($signed(sample));
      p.value  = SAMPLE_W'(sum >>> 2);
      p.row    = ROW_W'(r);
      p.column = COL_W'(c - 1);
      p.last   = (r + 1 == nrows) && (c + 1 == ncols);
      pending_points.push_back(p);
    end
    line_store[slot(c, r)] = sample;
    r++;
    if (r >= nrows) begin
      r = 0;
      c++;
      if (c >= ncols) c = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        note_error($sformatf("unexpected point value %0d row %0d col %0d",
                             $signed(out_tdata[SAMPLE_W-1:0]),
                             out_tdata[SAMPLE_W +: ROW_W], out_tdata[SAMPLE_W+ROW_W +: COL_W]));
      end else begin
        expected_point = pending_points.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== expected_point.value ||
            out_tdata[SAMPLE_W +: ROW_W] !== expected_point.row ||
            out_tdata[SAMPLE_W+ROW_W +: COL_W] !== expected_point.column ||
            out_tlast !== expected_point.last) begin
          note_error($sformatf({"point exp value %0d row %0d col %0d last %0b, ",
                                "got value %0d row %0d col %0d last %0b"},
                               $signed(expected_point.value), expected_point.row,
                               expected_point.column, expected_point.last,
                               $signed(out_tdata[SAMPLE_W-1:0]),
                               out_tdata[SAMPLE_W +: ROW_W],
                               out_tdata[SAMPLE_W+ROW_W +: COL_W], out_tlast));
        end
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    predict_point(sample);
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_run(input int unsigned count);
    logic [SAMPLE_W-1:0] s;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(11))
        0:       s = 32'h7fff_ffff;
        1:       s = 32'h8000_0000;
        2:       s = 32'hffff_ffff;
        3:       s = 32'h0000_0000;
        default: s = $urandom;
      endcase
      send_sample(s);
    end
    stop_input();
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_sel_t sel, input logic [APB_DW-1:0] data);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == REG_ROWS) rows_reg = data[CFG_ROWS_W-1:0];
    else cols_reg = data[CFG_COLS_W-1:0];
    next_row = 0;
    next_col = 0;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input reg_sel_t sel);
    logic [APB_DW-1:0] exp_data;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {sel, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    exp_data = (sel == REG_ROWS) ? APB_DW'(rows_reg) : APB_DW'(cols_reg);
    if (cfg_prdata !== exp_data) begin
      note_error($sformatf("register %s read exp %0d got %0d", sel.name(), exp_data,
                           cfg_prdata));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_grid(input int unsigned rows, input int unsigned cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  task automatic test_register_access();
    check_reg(REG_ROWS);
    check_reg(REG_COLS);
    write_reg(REG_ROWS, 32'hffff_ffff);
    write_reg(REG_COLS, 32'hffff_ffff);
    check_reg(REG_ROWS);
    check_reg(REG_COLS);
    write_reg(REG_ROWS, 32'h0000_0000);
    write_reg(REG_COLS, 32'h0000_0000);
    check_reg(REG_ROWS);
    check_reg(REG_COLS);
    write_reg(REG_ROWS, 32'h5555_0555);
    write_reg(REG_COLS, 32'haaaa_aaaa);
    check_reg(REG_ROWS);
    check_reg(REG_COLS);
  endtask

  // smallest grid, full scale samples, ghost columns and frame wrap
  task automatic test_directed_extremes();
    logic [SAMPLE_W-1:0] mix [8];
    mix = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'hffff_fffe,
            32'h7fff_ffff, 32'h8000_0000, 32'h0000_0003, 32'hffff_fffd};
    set_grid(2, 2);
    for (int i = 0; i < 8; i++) send_sample(32'h7fff_ffff);
    for (int i = 0; i < 8; i++) send_sample(32'h8000_0000);
    for (int i = 0; i < 8; i++) send_sample(mix[i]);
    stop_input();
  endtask

  // out of range sizes and odd row counts
  task automatic test_grid_limits();
    set_grid(0, 0);
    send_run(2 * frame_length() + 3);
    set_grid(1, 1);
    send_run(frame_length() + 2);
    set_grid(3, 2);
    send_run(2 * frame_length());
    set_grid(7, 3);
    send_run(frame_length() + 5);
    set_grid(2047, 2);
    send_run(40);
    set_grid(2, 4095);
    send_run(24);
  endtask

  // register writes restart the frame; one pause in mid frame until all points are out
  task automatic test_frame_restart();
    set_grid(6, 3);
    send_run(frame_length() + frame_length() / 2);
    wait_drained();
    send_run(11);
    write_reg(REG_COLS, 3);
    send_run(2 * frame_length());
    write_reg(REG_ROWS, 9);
    send_run(frame_length() - 4);
    write_reg(REG_ROWS, 4);
    send_run(frame_length() + 1);
  endtask

  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned items);
    int unsigned sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned flen;
    int unsigned n;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0:       rows = $urandom_range(0, 1);
        1:       rows = $urandom_range(13, 32);
        default: rows = $urandom_range(2, 12);
      endcase
      case ($urandom_range(9))
        0:       cols = $urandom_range(0, 1);
        1:       cols = $urandom_range(7, 10);
        default: cols = $urandom_range(2, 6);
      endcase
      case ($urandom_range(2))
        0:       write_reg(REG_ROWS, rows);
        1:       write_reg(REG_COLS, cols);
        default: set_grid(rows, cols);
      endcase
      flen = frame_length();
      if ($urandom_range(9) < 2) begin
        n = $urandom_range(1, flen - 1);
      end else begin
        n = flen * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) n += $urandom_range(1, flen - 1);
      end
      send_run(n);
      sent += n;
    end
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    errors        = 0;
    cycles        = 0;
    next_row      = 0;
    next_col      = 0;
    rows_reg      = ROWS_RESET;
    cols_reg      = COLS_RESET;
    in_idle_pct   = 15;
    out_stall_pct = 64;
    for (int i = 0; i < 2 * MAX_ROWS; i++) line_store[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_directed_extremes();
    test_grid_limits();
    test_frame_restart();
    test_random_frames(15, 64, 550);
    test_random_frames(64, 15, 550);
    test_random_frames(0, 0, 550);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
